[hw/rtl/pfa_pkg.sv]
`default_nettype none

package pfa_pkg;

   localparam int PAGE_COUNT_DEF = 512;
   localparam int PAGE_BYTES_DEF = 4096;

   localparam logic [6:0] REF_MAX   = 7'd127;
   localparam logic [9:0] FREED_MAX = 10'd1023;

   localparam logic [7:0] OWNER_KERNEL   = 8'hFE;
   localparam logic [7:0] OWNER_RESERVED = 8'hFF;

   typedef enum logic [2:0] {
      OP_ALLOC_ANY = 3'd0,
      OP_ALLOC_AT  = 3'd1,
      OP_SHARE     = 3'd2,
      OP_RELEASE   = 3'd3,
      OP_QUERY     = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_MEM   = 3'd1,
      ST_MISALIGN = 3'd2,
      ST_RANGE    = 3'd3,
      ST_USED     = 3'd4,
      ST_REFUSED  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [7:0] owner;
      logic [6:0] refc;
   } entry_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] owner;
      logic       act;
   } cmd_type;

   typedef struct packed {
      status_type status;
      logic [8:0] page;
      logic [7:0] owner;
      logic [6:0] refc;
      logic [9:0] freed;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/pfa_cell.sv]
`default_nettype none

module pfa_cell
   import pfa_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      shift,
   input  wire entry_type din,
   output entry_type      dout
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = shift ? din : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign dout = entry_ff;

endmodule

`default_nettype wire

[hw/rtl/pfa_head.sv]
`default_nettype none

module pfa_head
   import pfa_pkg::*;
#(
   parameter int CW = 9
) (
   input  wire cmd_type    cmd,
   input  wire logic [CW-1:0] tgt,
   input  wire logic [CW-1:0] page,
   input  wire entry_type  ent_in,
   input  wire result_type res_in,
   output entry_type       ent_out,
   output result_type      res_out
);

   logic hit;

   always_comb begin
      hit     = cmd.act && (page == tgt);
      ent_out = ent_in;
      res_out = res_in;
      case (cmd.op)
         OP_ALLOC_ANY: begin
            if (cmd.act && res_in.status == ST_NO_MEM && ent_in.refc == 7'd0) begin
               ent_out.owner  = cmd.owner;
               ent_out.refc   = 7'd1;
               res_out.status = ST_OK;
               res_out.page   = 9'(page);
               res_out.owner  = cmd.owner;
               res_out.refc   = 7'd1;
            end
         end
         OP_ALLOC_AT: begin
            if (hit) begin
               res_out.page = 9'(page);
               if (ent_in.refc != 7'd0) begin
                  res_out.status = ST_USED;
                  res_out.owner  = ent_in.owner;
                  res_out.refc   = ent_in.refc;
               end else begin
                  ent_out.owner  = cmd.owner;
                  ent_out.refc   = 7'd1;
                  res_out.status = ST_OK;
                  res_out.owner  = cmd.owner;
                  res_out.refc   = 7'd1;
               end
            end
         end
         OP_SHARE: begin
            if (hit) begin
               res_out.page  = 9'(page);
               res_out.owner = ent_in.owner;
               if (ent_in.refc == 7'd0 || $signed(ent_in.owner) <= 8'sd0) begin
                  res_out.status = ST_REFUSED;
                  res_out.refc   = ent_in.refc;
               end else begin
                  if (ent_in.refc != REF_MAX) begin
                     ent_out.refc = ent_in.refc + 7'd1;
                  end
                  res_out.status = ST_OK;
                  res_out.refc   = ent_out.refc;
               end
            end
         end
         OP_RELEASE: begin
            if (cmd.act && ent_in.owner == cmd.owner && ent_in.refc != 7'd0) begin
               ent_out = '0;
               if (res_in.freed != FREED_MAX) begin
                  res_out.freed = res_in.freed + 10'd1;
               end
            end
         end
         OP_QUERY: begin
            if (hit) begin
               res_out.status = ST_OK;
               res_out.page   = 9'(page);
               res_out.owner  = ent_in.owner;
               res_out.refc   = ent_in.refc;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/page_frame_allocator_top.sv]
`default_nettype none
// Every word is accepted in FSM_IDLE; the page entries sit in a ring of cells that turns
// once per word, one page passing the head unit each cycle in FSM_SCAN, and FSM_DONE
// loads the result into the output register. No new word is taken before FSM_IDLE.
// A new word is taken while an earlier result still waits in the output register.
// Synchronous reset clears every entry at once, so all pages are free in the next cycle.

module page_frame_allocator_top
   import pfa_pkg::*;
#(
   parameter int PAGE_COUNT = PAGE_COUNT_DEF,
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // phys_address [31:0], page_index [40:32], owner_id [48:41]
   input  wire logic [55:0] req_tdata,
   // opcode [2:0]
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // result_page [8:0], entry_owner [16:9], entry_refcount [23:17], freed_count [33:24]
   output logic [39:0]      rsp_tdata,
   // status [2:0]
   output logic [2:0]       rsp_tuser
);

   localparam int CW    = $clog2(PAGE_COUNT);
   localparam int OFF_W = $clog2(PAGE_BYTES);
   localparam logic [31:0]   OFF_MASK = 32'(PAGE_BYTES - 1);
   localparam logic [63:0]   LIMIT    = 64'(PAGE_COUNT) * 64'(PAGE_BYTES);
   localparam logic [CW-1:0] LAST     = CW'(PAGE_COUNT - 1);

   fsm_type    state_ff, state_in;
   logic [CW-1:0] page_ff, page_in;
   cmd_type    cmd_ff, cmd_in;
   logic [CW-1:0] tgt_ff, tgt_in;
   result_type res_ff, res_in;
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;

   op_type     req_op;
   logic [31:0] req_addr;
   logic [8:0] req_idx;
   logic [7:0] req_owner;
   logic       idx_bad;
   logic       shift;
   entry_type  head_ent, wb_ent;
   result_type res_next;
   entry_type  cell_out [PAGE_COUNT];

   assign req_op    = op_type'(req_tuser[2:0]);
   assign req_addr  = req_tdata[31:0];
   assign req_idx   = req_tdata[40:32];
   assign req_owner = req_tdata[48:41];
   assign idx_bad   = 32'(req_idx) >= 32'(PAGE_COUNT);
   assign head_ent  = cell_out[0];

   always_comb begin
      cmd_in.op    = req_op;
      cmd_in.owner = req_owner;
      cmd_in.act   = 1'b0;
      tgt_in       = CW'(req_idx);
      res_in       = '0;
      case (req_op)
         OP_ALLOC_ANY: begin
            cmd_in.act    = 1'b1;
            res_in.status = ST_NO_MEM;
         end
         OP_ALLOC_AT: begin
            tgt_in = CW'(req_addr >> OFF_W);
            if ((req_addr & OFF_MASK) != 32'd0) begin
               res_in.status = ST_MISALIGN;
            end else if ({32'd0, req_addr} >= LIMIT) begin
               res_in.status = ST_RANGE;
            end else begin
               cmd_in.act = 1'b1;
            end
         end
         OP_SHARE, OP_QUERY: begin
            if (idx_bad) begin
               res_in.status = ST_RANGE;
               res_in.page   = req_idx;
            end else begin
               cmd_in.act = 1'b1;
            end
         end
         OP_RELEASE: begin
            res_in.owner = req_owner;
            cmd_in.act   = (req_owner != OWNER_KERNEL) && (req_owner != OWNER_RESERVED);
         end
         default: begin
         end
      endcase
   end

   pfa_head #(
      .CW(CW)
   ) u_head (
      .cmd     (cmd_ff),
      .tgt     (tgt_ff),
      .page    (page_ff),
      .ent_in  (head_ent),
      .res_in  (res_ff),
      .ent_out (wb_ent),
      .res_out (res_next)
   );

   for (genvar i = 0; i < PAGE_COUNT; i++) begin : g_cell
      entry_type din;
      if (i == PAGE_COUNT - 1) begin : g_tail
         assign din = wb_ent;
      end else begin : g_link
         assign din = cell_out[i + 1];
      end
      pfa_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .din   (din),
         .dout  (cell_out[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      page_in      = page_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      shift        = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_tready = 1'b1;
            page_in    = '0;
            if (req_tvalid) begin
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            shift   = 1'b1;
            page_in = page_ff + CW'(1);
            if (page_ff == LAST) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         out_valid_ff <= 1'b0;
         page_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         page_ff      <= page_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (req_tvalid && req_tready) begin
         cmd_ff <= cmd_in;
         tgt_ff <= tgt_in;
         res_ff <= res_in;
      end else if (shift) begin
         res_ff <= res_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {6'd0, out_ff.freed, out_ff.refc, out_ff.owner, out_ff.page};

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == FSM_SCAN && page_ff == '0))
      else $error("accepted word did not start a ring revolution");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SCAN && page_ff == LAST) |=> (state_ff == FSM_DONE))
      else $error("ring revolution did not end after the last page");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_DONE && (!rsp_tvalid || rsp_tready))
         |=> (rsp_tvalid && state_ff == FSM_IDLE))
      else $error("finished result was not offered");

endmodule

`default_nettype wire
